FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the indexed list top module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ILIST_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ILIST_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ILIST_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg
// Types and constants of the indexed list with insert and erase.
// ----------------------------------------------------------------------------
package ilist_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam int KIND_W = 3;
   localparam int POS_W  = 5;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;
   localparam int SEL_W  = 9;   // holds any position or count up to 256

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_ERASE  = 3'd2,
      KIND_READ   = 3'd3,
      KIND_WRITE  = 3'd4
   } kind_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic             ins;
      logic             era;
      logic             wr;
      logic [SEL_W-1:0] pos;
   } cell_ctrl_type;

endpackage

FILE: hdl/ilist_cell.sv
// ----------------------------------------------------------------------------
// ilist_cell
// One list slot: holds a word, takes its left or right neighbor on a shift.
// ----------------------------------------------------------------------------
module ilist_cell
   import ilist_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [WORD_WIDTH-1:0] word_in,
   input  logic [WORD_WIDTH-1:0] left_in,
   input  logic [WORD_WIDTH-1:0] right_in,
   output logic [WORD_WIDTH-1:0] value_out
);

   localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(INDEX);

   logic [WORD_WIDTH-1:0] entry_ff;
   logic [WORD_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (MY_IDX > ctrl.pos) begin
            entry_in = left_in;
         end else if (MY_IDX == ctrl.pos) begin
            entry_in = word_in;
         end
      end else if (ctrl.era) begin
         if (MY_IDX >= ctrl.pos) begin
            entry_in = right_in;
         end
      end else if (ctrl.wr) begin
         if (MY_IDX == ctrl.pos) begin
            entry_in = word_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value_out = entry_ff;

endmodule

FILE: hdl/indexed_list_insert_erase.sv
// A response beat appears in the cycle after its request beat is accepted.
// Throughput: one request per cycle while rsp_tready stays high; the whole cell
// row shifts at once as the request is accepted, whatever the operation.
// Reset: clears the entry count and the response valid; stored words stay
// undefined until written.
// ----------------------------------------------------------------------------
// indexed_list_insert_erase
// Fixed-capacity ordered word list with append, insert, erase, read, write.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_insert_erase
   import ilist_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,   // position[4:0], value[36:5], zero pad
   input  logic [KIND_W-1:0] req_tuser,   // kind[2:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // read_value[31:0], list_length[36:32], zero pad
   output logic              rsp_tuser    // ok[0]
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [SEL_W-1:0] DEPTH_SEL = SEL_W'(DEPTH);

   logic [POS_W-1:0]      req_pos;
   logic [DATA_W-1:0]     req_value;
   kind_type              req_kind;
   logic                  req_fire;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SEL_W-1:0]      cnt_sel, pos_sel;
   logic                  full;
   logic                  op_ok;
   cell_ctrl_type         ctrl;
   logic [63:0]           value_ext, rd_ext;
   logic [WORD_WIDTH-1:0] word;
   logic [WORD_WIDTH-1:0] cell_q [DEPTH];
   logic [IDX_W-1:0]      rd_idx;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [LEN_W-1:0]      rsp_len_ff;

   assign req_pos   = req_tdata[POS_W-1:0];
   assign req_value = req_tdata[POS_W+DATA_W-1:POS_W];
   assign req_kind  = kind_type'(req_tuser);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign cnt_sel = SEL_W'(count_ff);
   assign pos_sel = {{(SEL_W-POS_W){1'b0}}, req_pos};
   assign full    = (cnt_sel == DEPTH_SEL);

   assign value_ext = {32'd0, req_value};
   assign word      = value_ext[WORD_WIDTH-1:0];
   assign rd_idx    = pos_sel[IDX_W-1:0];

   always_comb begin
      op_ok    = 1'b0;
      ctrl     = '0;
      ctrl.pos = pos_sel;
      count_in = count_ff;
      unique case (req_kind)
         KIND_APPEND: begin
            op_ok    = !full;
            ctrl.ins = req_fire && op_ok;
            ctrl.pos = cnt_sel;
         end
         KIND_INSERT: begin
            op_ok    = !full && (pos_sel <= cnt_sel);
            ctrl.ins = req_fire && op_ok;
         end
         KIND_ERASE: begin
            op_ok    = pos_sel < cnt_sel;
            ctrl.era = req_fire && op_ok;
         end
         KIND_READ: begin
            op_ok = pos_sel < cnt_sel;
         end
         KIND_WRITE: begin
            op_ok   = pos_sel < cnt_sel;
            ctrl.wr = req_fire && op_ok;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.era) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_w, right_w;
      if (gi == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = cell_q[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = cell_q[gi+1];
      end
      ilist_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .INDEX      (gi)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .word_in   (word),
         .left_in   (left_w),
         .right_in  (right_w),
         .value_out (cell_q[gi])
      );
   end

   always_comb begin
      rd_ext = '0;
      if (req_kind == KIND_READ && op_ok) begin
         rd_ext[WORD_WIDTH-1:0] = cell_q[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ok_ff   <= op_ok;
         rsp_data_ff <= rd_ext[DATA_W-1:0];
         rsp_len_ff  <= LEN_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'd0, rsp_len_ff, rsp_data_ff};

   `ILIST_ASSERT(a_count_bound, clock, reset, SEL_W'(count_ff) <= DEPTH_SEL, "count above depth")
   `ILIST_ASSERT_NXT(a_erase_dec, clock, reset, req_fire && op_ok && req_kind == KIND_ERASE, count_ff == $past(count_ff) - CNT_W'(1), "erase did not shrink list")
   `ILIST_ASSERT_IMP(a_refused_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_data_ff == '0, "refused beat carries data")

endmodule
